[src/nsd_pkg.sv]
`default_nettype none

package nsd_pkg;

   // Default limit on the length of one sentence, in bytes including the '$'; a sentence must stay below it.
   localparam int MAX_SENTENCE_DEFAULT = 128;

   // Event kinds on the result channel.
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_ERROR = 3'd1;
   localparam logic [2:0] KIND_CHA   = 3'd2;
   localparam logic [2:0] KIND_ACC   = 3'd3;
   localparam logic [2:0] KIND_REV   = 3'd4;
   localparam logic [2:0] KIND_SHO   = 3'd5;
   localparam logic [2:0] KIND_RES   = 3'd6;

   localparam int NUM_TYPES = 5;

   // Characters with a meaning in the sentence framing.
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   // Three-letter sentence type names, in the order CHA, ACC, REV, SHO, RES.
   typedef logic [7:0] name_type [NUM_TYPES][3];
   localparam name_type TYPE_NAMES = '{
      '{8'h43, 8'h48, 8'h41},
      '{8'h41, 8'h43, 8'h43},
      '{8'h52, 8'h45, 8'h56},
      '{8'h53, 8'h48, 8'h4F},
      '{8'h52, 8'h45, 8'h53}
   };

   // One decoded result.
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value_a;
      logic [31:0] value_b;
      logic [31:0] value_c;
   } event_type;

endpackage

`default_nettype wire

[src/nsd_parser.sv]
`default_nettype none

module nsd_parser #(
   parameter int MAX_SENTENCE = nsd_pkg::MAX_SENTENCE_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        rx_b,
   output nsd_pkg::event_type     evt
);
   import nsd_pkg::*;

   localparam int CW = $clog2(MAX_SENTENCE);
   localparam logic [CW-1:0] LIMIT = CW'(MAX_SENTENCE - 1);

   // Positions of the body decoder.
   localparam logic [2:0] POS_COMMA  = 3'd3;
   localparam logic [2:0] POS_FIELD  = 3'd4;
   localparam logic [2:0] POS_DIGITS = 3'd5;

   logic            receiving_ff, receiving_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [7:0]      xor_ff, xor_in;
   logic            past_star_ff, past_star_in;
   logic [1:0]      hex_seen_ff, hex_seen_in;
   logic [7:0]      sent_sum_ff, sent_sum_in;
   logic            sum_bad_ff, sum_bad_in;
   logic            last_cr_ff, last_cr_in;
   logic            zero_ff, zero_in;
   logic [2:0]      type_pos_ff, type_pos_in;
   logic [4:0]      type_match_ff, type_match_in;
   logic [1:0]      field_num_ff, field_num_in;
   logic            halted_ff, halted_in;
   logic [31:0]     value_ff [3];
   logic [31:0]     value_in [3];

   logic            is_digit;
   logic [3:0]      digit;
   logic [31:0]     cur_value;
   logic [35:0]     acc_value;
   logic [31:0]     new_value;
   logic            add_digit;
   logic [3:0]      hex_value;
   logic            found;
   logic [2:0]      found_idx;
   logic            bad;

   assign is_digit = (rx_b >= 8'h30) && (rx_b <= 8'h39);
   assign digit    = rx_b[3:0];

   // Value of the field now being built, times ten plus the new digit, saturating.
   always_comb begin
      case (field_num_ff)
         2'd0:    cur_value = value_ff[0];
         2'd1:    cur_value = value_ff[1];
         default: cur_value = value_ff[2];
      endcase
      acc_value = {1'b0, cur_value, 3'b000} + {3'b000, cur_value, 1'b0} + {32'd0, digit};
      new_value = (acc_value[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_value[31:0];
   end

   // Uppercase hex digit value of the byte.
   always_comb begin
      if (rx_b >= 8'h30 && rx_b <= 8'h39) begin
         hex_value = rx_b[3:0];
      end else if (rx_b >= 8'h41 && rx_b <= 8'h46) begin
         hex_value = rx_b[3:0] + 4'd9;
      end else begin
         hex_value = 4'd0;
      end
   end

   // Next parse state and the event that this byte produces.
   always_comb begin
      receiving_in  = receiving_ff;
      count_in      = count_ff;
      xor_in        = xor_ff;
      past_star_in  = past_star_ff;
      hex_seen_in   = hex_seen_ff;
      sent_sum_in   = sent_sum_ff;
      sum_bad_in    = sum_bad_ff;
      last_cr_in    = last_cr_ff;
      zero_in       = zero_ff;
      type_pos_in   = type_pos_ff;
      type_match_in = type_match_ff;
      field_num_in  = field_num_ff;
      halted_in     = halted_ff;
      value_in      = value_ff;
      add_digit     = 1'b0;
      found         = 1'b0;
      found_idx     = 3'd0;
      bad           = 1'b0;
      evt           = '0;

      if (rx_b == CHAR_DOLLAR) begin
         // A start character discards any partial sentence.
         receiving_in  = 1'b1;
         count_in      = CW'(1);
         xor_in        = 8'd0;
         past_star_in  = 1'b0;
         hex_seen_in   = 2'd0;
         sent_sum_in   = 8'd0;
         sum_bad_in    = 1'b0;
         last_cr_in    = 1'b0;
         zero_in       = 1'b0;
         type_pos_in   = 3'd0;
         type_match_in = '1;
         field_num_in  = 2'd0;
         halted_in     = 1'b0;
         value_in      = '{32'd0, 32'd0, 32'd0};
      end else if (receiving_ff) begin
         if (count_ff >= LIMIT) begin
            // Sentence too long.
            receiving_in = 1'b0;
            evt.kind     = KIND_ERROR;
         end else begin
            count_in = count_ff + CW'(1);
            if (!past_star_ff) begin
               if (rx_b == CHAR_STAR) begin
                  past_star_in = 1'b1;
               end else begin
                  xor_in = xor_ff ^ rx_b;
                  if (rx_b == 8'd0) begin
                     zero_in = 1'b1;
                  end
                  // Body decoding: type letters, then comma separated numbers.
                  if (!halted_ff) begin
                     if (type_pos_ff < POS_COMMA) begin
                        for (int k = 0; k < NUM_TYPES; k++) begin
                           if (TYPE_NAMES[k][type_pos_ff[1:0]] != rx_b) begin
                              type_match_in[k] = 1'b0;
                           end
                        end
                        type_pos_in = type_pos_ff + 3'd1;
                     end else if (type_pos_ff == POS_COMMA) begin
                        if (rx_b == CHAR_COMMA) begin
                           type_pos_in = POS_FIELD;
                        end else begin
                           halted_in = 1'b1;
                        end
                     end else if (type_pos_ff == POS_FIELD) begin
                        if (is_digit && field_num_ff < 2'd3) begin
                           add_digit   = 1'b1;
                           type_pos_in = POS_DIGITS;
                        end else begin
                           halted_in = 1'b1;
                        end
                     end else if (type_pos_ff == POS_DIGITS) begin
                        if (is_digit) begin
                           add_digit = 1'b1;
                        end else if (rx_b == CHAR_COMMA && field_num_ff < 2'd2) begin
                           field_num_in = field_num_ff + 2'd1;
                           type_pos_in  = POS_FIELD;
                        end else begin
                           halted_in = 1'b1;
                        end
                     end else begin
                        halted_in = 1'b1;
                     end
                  end
               end
            end else if (hex_seen_ff < 2'd2) begin
               // Checksum characters after the star.
               if (!((rx_b >= 8'h30 && rx_b <= 8'h39) || (rx_b >= 8'h41 && rx_b <= 8'h46))) begin
                  sum_bad_in = 1'b1;
               end
               sent_sum_in = {sent_sum_ff[3:0], hex_value};
               hex_seen_in = hex_seen_ff + 2'd1;
            end

            if (add_digit) begin
               case (field_num_ff)
                  2'd0:    value_in[0] = new_value;
                  2'd1:    value_in[1] = new_value;
                  default: value_in[2] = new_value;
               endcase
            end

            last_cr_in = (rx_b == CHAR_CR);

            // End of sentence: check it and report.
            if (rx_b == CHAR_LF && last_cr_ff) begin
               receiving_in = 1'b0;
               for (int k = NUM_TYPES - 1; k >= 0; k--) begin
                  if (type_match_in[k]) begin
                     found     = 1'b1;
                     found_idx = 3'(k);
                  end
               end
               bad = !past_star_in || zero_in || sum_bad_in || (hex_seen_in < 2'd2) ||
                     (sent_sum_in != xor_in) || (type_pos_in < POS_COMMA) || !found;
               if (bad) begin
                  evt.kind = KIND_ERROR;
               end else begin
                  evt.kind    = KIND_CHA + found_idx;
                  evt.value_a = value_in[0];
                  evt.value_b = (evt.kind == KIND_SHO || evt.kind == KIND_RES) ?
                                value_in[1] : 32'd0;
                  evt.value_c = (evt.kind == KIND_RES) ? value_in[2] : 32'd0;
               end
            end
         end
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff  <= 1'b0;
         count_ff      <= '0;
         xor_ff        <= 8'd0;
         past_star_ff  <= 1'b0;
         hex_seen_ff   <= 2'd0;
         sent_sum_ff   <= 8'd0;
         sum_bad_ff    <= 1'b0;
         last_cr_ff    <= 1'b0;
         zero_ff       <= 1'b0;
         type_pos_ff   <= 3'd0;
         type_match_ff <= '1;
         field_num_ff  <= 2'd0;
         halted_ff     <= 1'b0;
         value_ff      <= '{32'd0, 32'd0, 32'd0};
      end else if (step) begin
         receiving_ff  <= receiving_in;
         count_ff      <= count_in;
         xor_ff        <= xor_in;
         past_star_ff  <= past_star_in;
         hex_seen_ff   <= hex_seen_in;
         sent_sum_ff   <= sent_sum_in;
         sum_bad_ff    <= sum_bad_in;
         last_cr_ff    <= last_cr_in;
         zero_ff       <= zero_in;
         type_pos_ff   <= type_pos_in;
         type_match_ff <= type_match_in;
         field_num_ff  <= field_num_in;
         halted_ff     <= halted_in;
         value_ff      <= value_in;
      end
   end

endmodule

`default_nettype wire

[src/nmea_sentence_decoder.sv]
// Byte-serial decoder of "$<type>,<n>,<n>,<n>*HH\r\n" sentences with XOR checksum.
// Input channel: req_rx_byte with req_valid/req_ready, one received character per
// transaction. Result channel: rsp_event_kind and rsp_value_a/b/c with
// rsp_valid/rsp_ready. Every input byte yields exactly one result: kind none for
// bytes inside or outside a sentence, error on a byte past the length limit, and
// error or a typed event with its numbers on the line feed that closes a sentence.
// An accepted byte is held in the input register and then passes through the parse
// logic into the result register, which drives the outputs; it waits in the input
// register while the result register is full and not being taken. One byte is
// taken every cycle while the result side takes results; the parse state is
// updated once per byte by a single pass of logic.
// When rsp_ready is low the result register holds, and the input register still
// takes one more byte, after which req_ready drops until the result is taken.
// Reset (synchronous, active high) empties both registers and leaves the parser
// idle, waiting for a '$'.
`default_nettype none

module nmea_sentence_decoder #(
   parameter int MAX_SENTENCE = nsd_pkg::MAX_SENTENCE_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_kind,
   output logic [31:0]      rsp_value_a,
   output logic [31:0]      rsp_value_b,
   output logic [31:0]      rsp_value_c
);
   import nsd_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   event_type   out_evt_ff;
   event_type   evt;
   logic        advance;

   // A held byte moves on when the result register is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   nsd_parser #(
      .MAX_SENTENCE(MAX_SENTENCE)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .rx_b  (in_byte_ff),
      .evt   (evt)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_evt_ff <= evt;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_evt_ff.kind;
   assign rsp_value_a    = out_evt_ff.value_a;
   assign rsp_value_b    = out_evt_ff.value_b;
   assign rsp_value_c    = out_evt_ff.value_c;

endmodule

`default_nettype wire

[dv/tb_nmea_sentence_decoder.sv]
`timescale 1ns / 1ps

module tb_nmea_sentence_decoder;
   import nsd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned TOTAL_ITEMS = 1400;

   localparam logic [7:0] ASCII_0  = "0";
   localparam logic [7:0] ASCII_9  = "9";
   localparam logic [7:0] ASCII_A  = "A";
   localparam logic [7:0] ASCII_F  = "F";
   localparam logic [7:0] ASCII_LA = "a";
   localparam logic [7:0] ASCII_X  = "X";
   localparam logic [7:0] ASCII_Z  = "Z";
   localparam logic [7:0] ASCII_HASH = "#";

   typedef logic [7:0] byte_q_type[$];

   // How a sentence is closed after its body.
   typedef enum {
      FRAME_GOOD, FRAME_LOWER_SUM, FRAME_WRONG_SUM, FRAME_ONE_DIGIT,
      FRAME_TRAILER, FRAME_NO_STAR
   } frame_end_type;

   // Where the decoder stands within the body of a sentence.
   typedef enum int unsigned {
      AT_NAME0, AT_NAME1, AT_NAME2, AT_COMMA, AT_FIELD_START, AT_DIGITS
   } parse_pos_type;

   // Decodes the accepted byte stream on its own and checks each result in order.
   class nmea_scoreboard;
      bit                   in_sentence;
      int unsigned          byte_count;
      logic [7:0]           body_xor;
      bit                   star_seen;
      int unsigned          sum_digits;
      logic [7:0]           sum_received;
      bit                   sum_invalid;
      bit                   prev_cr;
      bit                   nul_in_body;
      parse_pos_type        name_pos;
      logic [NUM_TYPES-1:0] name_hits;
      int unsigned          field_idx;
      bit                   fields_done;
      logic [31:0]          field_val [3];
      int unsigned          fields_of_type [NUM_TYPES] = '{1, 1, 1, 2, 3};

      event_type            due_events[$];
      int unsigned          mismatches;
      int unsigned          results_seen;
      int unsigned          bytes_parsed;
      int unsigned          items_noted;
      int unsigned          kind_seen [8];

      function new();
         in_sentence = 1'b0;
         restart_parse();
      endfunction

      function void restart_parse();
         byte_count   = 0;
         body_xor     = '0;
         star_seen    = 1'b0;
         sum_digits   = 0;
         sum_received = '0;
         sum_invalid  = 1'b0;
         prev_cr      = 1'b0;
         nul_in_body  = 1'b0;
         name_pos     = AT_NAME0;
         name_hits    = '1;
         field_idx    = 0;
         fields_done  = 1'b0;
         foreach (field_val[i]) field_val[i] = '0;
      endfunction

      function bit is_dec(logic [7:0] ch);
         return ch >= ASCII_0 && ch <= ASCII_9;
      endfunction

      // Accumulates one decimal digit, pinning the value at all ones on overflow.
      function void push_digit(logic [7:0] ch);
         logic [63:0] acc;
         acc = 64'(field_val[field_idx]) * 64'd10 + 64'(ch - ASCII_0);
         field_val[field_idx] = (acc > 64'hFFFF_FFFF) ? '1 : acc[31:0];
      endfunction

      // Type letters, then comma separated decimal fields.
      function void body_char(logic [7:0] ch);
         if (fields_done) return;
         case (name_pos)
            AT_NAME0, AT_NAME1, AT_NAME2: begin
               for (int k = 0; k < NUM_TYPES; k++)
                  if (TYPE_NAMES[k][int'(name_pos)] != ch) name_hits[k] = 1'b0;
               name_pos = parse_pos_type'(name_pos + 1);
            end
            AT_COMMA: begin
               if (ch == CHAR_COMMA) name_pos = AT_FIELD_START;
               else fields_done = 1'b1;
            end
            AT_FIELD_START: begin
               if (is_dec(ch) && field_idx < 3) begin
                  push_digit(ch);
                  name_pos = AT_DIGITS;
               end else begin
                  fields_done = 1'b1;
               end
            end
            AT_DIGITS: begin
               if (is_dec(ch)) begin
                  push_digit(ch);
               end else if (ch == CHAR_COMMA && field_idx < 2) begin
                  field_idx++;
                  name_pos = AT_FIELD_START;
               end else begin
                  fields_done = 1'b1;
               end
            end
            default: fields_done = 1'b1;
         endcase
      endfunction

      // Only the first two characters after the star form the checksum.
      function void sum_char(logic [7:0] ch);
         logic [7:0] nibble;
         if (sum_digits >= 2) return;
         nibble = '0;
         if (is_dec(ch)) nibble = ch - ASCII_0;
         else if (ch >= ASCII_A && ch <= ASCII_F) nibble = ch - ASCII_A + 8'd10;
         else sum_invalid = 1'b1;
         sum_received = {sum_received[3:0], nibble[3:0]};
         sum_digits++;
      endfunction

      function event_type close_sentence();
         event_type res;
         int        found;
         res   = '0;
         found = -1;
         for (int k = 0; k < NUM_TYPES; k++)
            if (name_hits[k] && found < 0) found = k;
         if (!star_seen || nul_in_body || sum_invalid || sum_digits < 2 ||
             sum_received != body_xor || name_pos < AT_COMMA || found < 0) begin
            res.kind = KIND_ERROR;
            return res;
         end
         res.kind    = KIND_CHA + 3'(found);
         res.value_a = field_val[0];
         if (fields_of_type[found] >= 2) res.value_b = field_val[1];
         if (fields_of_type[found] >= 3) res.value_c = field_val[2];
         return res;
      endfunction

      // Called for every accepted input transaction; each yields one result.
      function void note_rx_byte(logic [7:0] ch);
         event_type res;
         bit        was_cr;
         res = '0;
         items_noted++;
         if (ch == CHAR_DOLLAR) begin
            restart_parse();
            in_sentence = 1'b1;
            byte_count  = 1;
            bytes_parsed++;
         end else if (in_sentence) begin
            bytes_parsed++;
            if (byte_count >= MAX_SENTENCE_DEFAULT - 1) begin
               in_sentence = 1'b0;
               res.kind    = KIND_ERROR;
            end else begin
               byte_count++;
               if (!star_seen) begin
                  if (ch == CHAR_STAR) begin
                     star_seen = 1'b1;
                  end else begin
                     body_xor ^= ch;
                     if (ch == 8'h00) nul_in_body = 1'b1;
                     body_char(ch);
                  end
               end else begin
                  sum_char(ch);
               end
               was_cr  = prev_cr;
               prev_cr = (ch == CHAR_CR);
               if (ch == CHAR_LF && was_cr) begin
                  in_sentence = 1'b0;
                  res = close_sentence();
               end
            end
         end
         due_events.push_back(res);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_event(logic [2:0] kind, logic [31:0] a, logic [31:0] b,
                                logic [31:0] c);
         event_type want;
         results_seen++;
         if (due_events.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected, expected nothing, actual kind %0d",
                     $time, kind);
            return;
         end
         want = due_events.pop_front();
         kind_seen[want.kind]++;
         compare_field("event_kind", 32'(want.kind), 32'(kind));
         compare_field("value_a", want.value_a, a);
         compare_field("value_b", want.value_b, b);
         compare_field("value_c", want.value_c, c);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [31:0] rsp_value_a;
   logic [31:0] rsp_value_b;
   logic [31:0] rsp_value_c;

   nmea_scoreboard sb;
   int unsigned    burst_left = 0;
   int unsigned    cycle_count;
   int unsigned    holds_done = 0;
   bit             hold_request = 1'b0;

   nmea_sentence_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_value_a    (rsp_value_a),
      .rsp_value_b    (rsp_value_b),
      .rsp_value_c    (rsp_value_c)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic byte_q_type text_bytes(string s);
      byte_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic void append_text(ref byte_q_type dst, input string s);
      for (int i = 0; i < s.len(); i++) dst.push_back(s[i]);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
      if (n < 4'd10) return ASCII_0 + 8'(n);
      return (lower ? ASCII_LA : ASCII_A) + 8'(n) - 8'd10;
   endfunction

   // Offers one byte as an input transaction; the sender may idle between bursts.
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_rx_byte(b);
   endtask

   // Drops valid and waits until every predicted result has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.due_events.size() != 0) @(posedge clock);
   endtask

   // Sends '$', the body, and a closing chosen by ending; cut truncates the frame.
   task automatic send_frame(input byte_q_type body, input frame_end_type ending,
                             input int unsigned cut);
      byte_q_type  q;
      logic [7:0]  sum;
      logic [7:0]  bad;
      int unsigned n;
      sum = '0;
      foreach (body[i]) sum ^= body[i];
      q.push_back(CHAR_DOLLAR);
      foreach (body[i]) q.push_back(body[i]);
      if (ending != FRAME_NO_STAR) begin
         q.push_back(CHAR_STAR);
         case (ending)
            FRAME_LOWER_SUM: begin
               q.push_back(hex_char(sum[7:4], 1'b1));
               q.push_back(hex_char(sum[3:0], 1'b1));
            end
            FRAME_WRONG_SUM: begin
               bad = sum ^ 8'($urandom_range(1, 255));
               q.push_back(hex_char(bad[7:4], 1'b0));
               q.push_back(hex_char(bad[3:0], 1'b0));
            end
            FRAME_ONE_DIGIT: q.push_back(hex_char(sum[7:4], 1'b0));
            default: begin
               q.push_back(hex_char(sum[7:4], 1'b0));
               q.push_back(hex_char(sum[3:0], 1'b0));
            end
         endcase
         if (ending == FRAME_TRAILER) append_text(q, "7Q");
      end
      q.push_back(CHAR_CR);
      q.push_back(CHAR_LF);
      n = (cut == 0 || cut > q.size()) ? q.size() : cut;
      for (int i = 0; i < n; i++) send_byte(q[i]);
   endtask

   // Mostly well-formed bodies with random numbers, plus occasional damage.
   function automatic byte_q_type random_body();
      byte_q_type  q;
      int unsigned kind;
      int unsigned count;
      int unsigned pad_to;
      logic [7:0]  ch;
      string       letters;
      letters = "CHAREVSOX";
      if ($urandom_range(0, 9) != 0) begin
         kind = $urandom_range(0, NUM_TYPES - 1);
         for (int k = 0; k < 3; k++) q.push_back(TYPE_NAMES[kind][k]);
      end else begin
         count = $urandom_range(0, 3);
         for (int k = 0; k < count; k++)
            q.push_back(letters[$urandom_range(0, letters.len() - 1)]);
      end
      if ($urandom_range(0, 9) != 0) begin
         q.push_back(CHAR_COMMA);
         count = $urandom_range(0, 4);
         for (int k = 0; k < count; k++) begin
            if (k != 0) q.push_back(CHAR_COMMA);
            case ($urandom_range(0, 5))
               0: append_text(q, $sformatf("%0d", $urandom_range(0, 999)));
               1: append_text(q, $sformatf("%0d", $urandom()));
               2: repeat ($urandom_range(10, 14))
                     q.push_back(8'(ASCII_0 + $urandom_range(0, 9)));
               3: ;
               4: append_text(q, $sformatf("000%0d", $urandom_range(0, 99)));
               default: append_text(q, $sformatf("%0d",
                                     64'd4294967290 + 64'($urandom_range(0, 9))));
            endcase
         end
      end
      // Free text after the fields.
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 8)) begin
            ch = 8'($urandom_range(32, 126));
            if (ch == CHAR_DOLLAR || ch == CHAR_STAR) ch = ASCII_HASH;
            q.push_back(ch);
         end
      end
      // A single corrupted character anywhere in the body.
      if ($urandom_range(0, 19) == 0 && q.size() != 0)
         q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      // Now and then a long body near the length limit, on either side of it.
      if ($urandom_range(0, 29) == 0) begin
         pad_to = $urandom_range(110, 130);
         while (q.size() < pad_to) q.push_back(ASCII_Z);
      end
      return q;
   endfunction

   // Result side: takes a transaction whenever valid and ready meet at an edge.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready)
            sb.check_event(rsp_event_kind, rsp_value_a, rsp_value_b, rsp_value_c);
      end
   end

   // Receiver stall pattern, with one long hold-off on request.
   initial begin
      int unsigned rx_phase;
      rx_phase = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            holds_done++;
         end else begin
            case ((rx_phase / 97) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ((rx_phase % 5) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            rx_phase++;
            @(posedge clock);
         end
      end
   end

   // Watchdog.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_nmea_sentence_decoder: errors");
      $finish;
   end

   initial begin
      byte_q_type    body;
      int unsigned   random_start;
      int unsigned   pick;
      frame_end_type ending;
      bit            hold_asked;
      bit            pause_done;
      int unsigned   typed;

      sb = new();
      hold_asked = 1'b0;
      pause_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Bytes outside a sentence are ignored.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);

      // Every type, field extremes and saturation.
      send_frame(text_bytes("CHA,0"), FRAME_GOOD, 0);
      send_frame(text_bytes("ACC,4294967295"), FRAME_GOOD, 0);
      send_frame(text_bytes("REV,4294967296"), FRAME_GOOD, 0);
      send_frame(text_bytes("REV,99999999999999"), FRAME_GOOD, 0);
      send_frame(text_bytes("SHO,12,34"), FRAME_GOOD, 0);
      send_frame(text_bytes("RES,1,2,3"), FRAME_GOOD, 0);
      send_frame(text_bytes("RES,7"), FRAME_GOOD, 0);
      send_frame(text_bytes("SHO"), FRAME_GOOD, 0);
      send_frame(text_bytes("CHA,5,6,7,8"), FRAME_GOOD, 0);

      // Field decoding stops at blanks, signs and empty fields.
      send_frame(text_bytes("CHA, 5"), FRAME_GOOD, 0);
      send_frame(text_bytes("ACC,-5"), FRAME_GOOD, 0);
      send_frame(text_bytes("RES,1,,3"), FRAME_GOOD, 0);

      // Checksum problems: lowercase, wrong value, one digit, text after it, no star.
      send_frame(text_bytes("ACC,10"), FRAME_LOWER_SUM, 0);
      send_frame(text_bytes("SHO,1,2"), FRAME_WRONG_SUM, 0);
      send_frame(text_bytes("CHA,9"), FRAME_ONE_DIGIT, 0);
      send_frame(text_bytes("RES,4,5,6"), FRAME_TRAILER, 0);
      send_frame(text_bytes("REV,3"), FRAME_NO_STAR, 0);

      // A zero byte in the body, short bodies and names that do not match.
      body = text_bytes("REV,77");
      body.push_back(8'h00);
      send_frame(body, FRAME_GOOD, 0);
      send_frame(text_bytes("CH"), FRAME_GOOD, 0);
      send_frame(text_bytes(""), FRAME_GOOD, 0);
      send_frame(text_bytes("CHX,1"), FRAME_GOOD, 0);
      send_frame(text_bytes(" CHA,1"), FRAME_GOOD, 0);
      send_frame(text_bytes("cha,1"), FRAME_GOOD, 0);

      // A '$' restarts a partial sentence.
      send_frame(text_bytes("RES,9,9"), FRAME_GOOD, 6);
      send_frame(text_bytes("SHO,5,6"), FRAME_GOOD, 0);

      // Carriage return without line feed, line feed alone, and early end.
      body = text_bytes("CHA,1");
      body.push_back(CHAR_CR);
      body.push_back(ASCII_X);
      send_frame(body, FRAME_GOOD, 0);
      body = text_bytes("SHO,8");
      body.push_back(CHAR_LF);
      send_frame(body, FRAME_GOOD, 0);
      body = text_bytes("CHA,3");
      body.push_back(CHAR_CR);
      body.push_back(CHAR_LF);
      send_frame(body, FRAME_GOOD, 0);

      // Length limit: a sentence that exactly fits, then one a byte too long.
      body = text_bytes("CHA,42");
      while (body.size() < MAX_SENTENCE_DEFAULT - 7) body.push_back(ASCII_Z);
      send_frame(body, FRAME_GOOD, 0);
      body.push_back(ASCII_Z);
      send_frame(body, FRAME_GOOD, 0);
      wait_drained();

      // Random traffic: mostly sentences, some truncated, some line noise.
      random_start = sb.items_noted;
      while (sb.items_noted < TOTAL_ITEMS) begin
         if (!hold_asked && sb.items_noted >= random_start + 200) begin
            hold_request = 1'b1;
            hold_asked   = 1'b1;
         end
         if (!pause_done && sb.items_noted >= random_start + 450) begin
            wait_drained();
            pause_done = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            case ($urandom_range(0, 99)) inside
               [0:69]:  ending = FRAME_GOOD;
               [70:75]: ending = FRAME_LOWER_SUM;
               [76:83]: ending = FRAME_WRONG_SUM;
               [84:87]: ending = FRAME_ONE_DIGIT;
               [88:93]: ending = FRAME_TRAILER;
               default: ending = FRAME_NO_STAR;
            endcase
            send_frame(random_body(), ending, 0);
         end else if (pick < 87) begin
            body = random_body();
            send_frame(body, FRAME_GOOD, $urandom_range(1, body.size() + 4));
         end else begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);

      typed = 0;
      for (int k = KIND_CHA; k <= KIND_RES; k++) typed += sb.kind_seen[k];
      $display("Checked %0d results for %0d input bytes (%0d inside sentences): %0d decoded, %0d errors.",
               sb.results_seen, sb.items_noted, sb.bytes_parsed, typed,
               sb.kind_seen[KIND_ERROR]);
      $display("Receiver held off %0d time(s) for %0d cycles; %0d mismatches found.",
               holds_done, HOLD_CYCLES, sb.mismatches);
      if (sb.mismatches == 0 && sb.due_events.size() == 0) begin
         $display("tb_nmea_sentence_decoder: clean");
      end else begin
         $display("tb_nmea_sentence_decoder: errors");
      end
      $finish;
   end

endmodule

[nmea_sentence_decoder.f]
src/nsd_pkg.sv
src/nsd_parser.sv
src/nmea_sentence_decoder.sv
dv/tb_nmea_sentence_decoder.sv
